[hdl/rmd_pkg.sv]
package rmd_pkg;

	localparam int unsigned LEN_W = 31;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned HDR_W = 32;
	localparam int unsigned HDR_BYTES = 4;
	localparam int unsigned HCNT_W = $clog2(HDR_BYTES);

	localparam logic [LEN_W-1:0] MAX_LEN_RESET = LEN_W'(1048576);
	localparam logic [HCNT_W-1:0] HCNT_LAST = HCNT_W'(HDR_BYTES - 1);

	typedef enum logic [2:0] {
		ST_BODY     = 3'd0,
		ST_EMPTY    = 3'd1,
		ST_FRAGMENT = 3'd2,
		ST_TOO_LONG = 3'd3,
		ST_CLOSE    = 3'd4,
		ST_RESET    = 3'd5
	} status_t;

	typedef enum logic {
		MODE_BYTE = 1'b0,
		MODE_EOS  = 1'b1
	} mode_t;

	typedef struct packed {
		logic              vld;
		status_t           status;
		logic [BYTE_W-1:0] body_byte;
		logic              last;
	} result_t;

endpackage

[hdl/record_marking_deframer_unit.sv]
// Channel  | handshake                  | payload
// ---------+----------------------------+--------------------------------------
// item     | item_valid / item_stall    | mode, stream_byte
// result   | result_valid / result_stall| status, body_byte, last
// cfg      | cfg_valid / cfg_ready      | max_message_length
//
// One word a cycle sustained while result_stall is low; a word's result reaches
// the result port through the input register followed by the result register.
// The header counter, length counter and bounds compare sit in one stage.
// arst_n clears all control state and loads the length limit with 1 MiB.
// result_stall holds the result register; a one-word input skid behind the
// input register keeps item_stall a plain register output.
module record_marking_deframer_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	output logic                       item_stall,
	input  logic                       mode,
	input  logic [rmd_pkg::BYTE_W-1:0] stream_byte,
	output logic                       result_valid,
	input  logic                       result_stall,
	output logic [2:0]                 status,
	output logic [rmd_pkg::BYTE_W-1:0] body_byte,
	output logic                       last,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [rmd_pkg::LEN_W-1:0]  max_message_length
);

	logic                       max_len_wr;
	logic [rmd_pkg::LEN_W-1:0]  max_len_q;

	logic                       item_fire;
	logic                       valid_s1;
	logic                       mode_s1;
	logic [rmd_pkg::BYTE_W-1:0] byte_s1;
	logic                       skid_valid_q;
	logic                       skid_mode_q;
	logic [rmd_pkg::BYTE_W-1:0] skid_byte_q;
	logic                       s1_load;
	logic                       adv;
	logic                       out_free;
	rmd_pkg::result_t           res;

	logic                       out_valid_q;
	rmd_pkg::status_t           status_q;
	logic [rmd_pkg::BYTE_W-1:0] body_q;
	logic                       last_q;

	// the limit must only change while idle; the block does not enforce it and takes every write
	assign cfg_ready  = 1'b1;
	assign max_len_wr = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= rmd_pkg::MAX_LEN_RESET;
		end else if (max_len_wr) begin
			max_len_q <= max_message_length;
		end
	end

	// stall only once the skid word is occupied
	assign item_stall = skid_valid_q;
	assign item_fire  = item_valid && !item_stall;

	// advance the stage word unless it has a result and the output is blocked
	assign out_free = !out_valid_q || !result_stall;
	assign adv      = valid_s1 && (!res.vld || out_free);
	assign s1_load  = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (s1_load) begin
			if (skid_valid_q) begin
				valid_s1     <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				valid_s1 <= item_fire;
			end
		end else if (item_fire) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_load) begin
			if (skid_valid_q) begin
				mode_s1 <= skid_mode_q;
				byte_s1 <= skid_byte_q;
			end else begin
				mode_s1 <= mode;
				byte_s1 <= stream_byte;
			end
		end else if (item_fire) begin
			skid_mode_q <= mode;
			skid_byte_q <= stream_byte;
		end
	end

	// framing state and the per-word decision
	rmd_frame_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (adv),
		.mode    (mode_s1),
		.data    (byte_s1),
		.max_len (max_len_q),
		.res     (res)
	);

	// result register: load on a producing step, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && res.vld) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res.vld) begin
			status_q <= res.status;
			body_q   <= res.body_byte;
			last_q   <= res.last;
		end
	end

	assign result_valid = out_valid_q;
	assign status       = status_q;
	assign body_byte    = body_q;
	assign last         = last_q;

`ifndef SYNTHESIS
	// the skid word is only ever filled behind a held stage word
	assert property (@(posedge clk) disable iff (!arst_n) skid_valid_q |-> valid_s1)
		else $error("skid occupied with empty stage");
	// never overwrite a result that is still held
	assert property (@(posedge clk) disable iff (!arst_n)
		!(adv && res.vld && out_valid_q && result_stall))
		else $error("result overwritten while stalled");
	// a stage word blocked by the output stays in place
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(byte_s1) && $stable(mode_s1))
		else $error("blocked stage word lost");
`endif

endmodule

[hdl/rmd_frame_core.sv]
module rmd_frame_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step_en,
	input  logic                       mode,
	input  logic [rmd_pkg::BYTE_W-1:0] data,
	input  logic [rmd_pkg::LEN_W-1:0]  max_len,
	output rmd_pkg::result_t           res
);

	logic [rmd_pkg::HCNT_W-1:0]             hcnt_q, hcnt_d;
	logic [rmd_pkg::HDR_W-rmd_pkg::BYTE_W-1:0] hval_q, hval_d;
	logic [rmd_pkg::LEN_W-1:0]              rem_q, rem_d;
	logic                                   in_body_q, in_body_d;
	logic                                   halted_q, halted_d;
	logic [rmd_pkg::HDR_W-1:0]              hdr_full;
	logic [rmd_pkg::LEN_W-1:0]              hdr_len;

	assign hdr_full = {hval_q, data};
	assign hdr_len  = hdr_full[rmd_pkg::LEN_W-1:0];

	always_comb begin
		hcnt_d        = hcnt_q;
		hval_d        = hval_q;
		rem_d         = rem_q;
		in_body_d     = in_body_q;
		halted_d      = halted_q;
		res.vld       = 1'b0;
		res.status    = rmd_pkg::ST_BODY;
		res.body_byte = '0;
		res.last      = 1'b0;
		if (halted_q) begin
			// drop everything until reset
		end else if (mode == rmd_pkg::MODE_EOS) begin
			res.vld    = 1'b1;
			res.status = (!in_body_q && hcnt_q == '0) ? rmd_pkg::ST_CLOSE : rmd_pkg::ST_RESET;
			hcnt_d     = '0;
			hval_d     = '0;
			rem_d      = '0;
			in_body_d  = 1'b0;
		end else if (in_body_q) begin
			res.vld       = 1'b1;
			res.body_byte = data;
			rem_d         = rem_q - rmd_pkg::LEN_W'(1);
			if (rem_q == rmd_pkg::LEN_W'(1)) begin
				res.last  = 1'b1;
				in_body_d = 1'b0;
			end
		end else if (hcnt_q != rmd_pkg::HCNT_LAST) begin
			hcnt_d = hcnt_q + rmd_pkg::HCNT_W'(1);
			hval_d = hdr_full[rmd_pkg::HDR_W-rmd_pkg::BYTE_W-1:0];
		end else if (!hdr_full[rmd_pkg::HDR_W-1]) begin
			res.vld    = 1'b1;
			res.status = rmd_pkg::ST_FRAGMENT;
			halted_d   = 1'b1;
		end else begin
			hcnt_d = '0;
			hval_d = '0;
			if (hdr_len == '0) begin
				res.vld    = 1'b1;
				res.status = rmd_pkg::ST_EMPTY;
			end else if (hdr_len > max_len) begin
				res.vld    = 1'b1;
				res.status = rmd_pkg::ST_TOO_LONG;
				halted_d   = 1'b1;
			end else begin
				rem_d     = hdr_len;
				in_body_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hcnt_q    <= '0;
			hval_q    <= '0;
			rem_q     <= '0;
			in_body_q <= 1'b0;
			halted_q  <= 1'b0;
		end else if (step_en) begin
			hcnt_q    <= hcnt_d;
			hval_q    <= hval_d;
			rem_q     <= rem_d;
			in_body_q <= in_body_d;
			halted_q  <= halted_d;
		end
	end

`ifndef SYNTHESIS
	// a body in progress always has bytes left
	assert property (@(posedge clk) disable iff (!arst_n) in_body_q |-> rem_q != '0)
		else $error("body active with zero remaining");
	// an error halt never leaves a body open
	assert property (@(posedge clk) disable iff (!arst_n) halted_q |-> !in_body_q)
		else $error("halted while in body");
	// no header bytes are gathered while a body is passed on
	assert property (@(posedge clk) disable iff (!arst_n) in_body_q |-> hcnt_q == '0)
		else $error("header count live inside a body");
`endif

endmodule

[tb/record_marking_deframer_unit_test.sv]
`timescale 1ns / 1ps

module record_marking_deframer_unit_test;

	// Bound on consecutive cycles in which no word moves on any channel
	localparam int unsigned QUIET_LIMIT = 5000;
	// Cycles to let header words settle through the pipe before a register write
	localparam int unsigned SETTLE_CYCLES = 16;
	localparam int unsigned PHASES = 6;
	localparam int unsigned PHASE_WORDS = 270;

	typedef struct packed {
		rmd_pkg::status_t                status;
		logic [rmd_pkg::BYTE_W-1:0]      body_byte;
		logic                            last;
	} framed_word_t;

	// Tracks the framing state alongside the block and holds the result words
	// it owes us, oldest first.
	class deframe_scoreboard;
		logic [rmd_pkg::LEN_W-1:0]  max_len;
		logic [2:0]                 hdr_count;
		logic [rmd_pkg::HDR_W-1:0]  hdr_value;
		logic [rmd_pkg::LEN_W-1:0]  bytes_left;
		bit                         in_body;
		bit                         halted;
		framed_word_t               owed_words[$];
		int unsigned                mismatches;

		function new();
			max_len = rmd_pkg::MAX_LEN_RESET;
			restart_framing();
			halted = 1'b0;
			mismatches = 0;
		endfunction

		function void restart_framing();
			hdr_count = '0;
			hdr_value = '0;
			bytes_left = '0;
			in_body = 1'b0;
		endfunction

		function void owe(rmd_pkg::status_t s, logic [rmd_pkg::BYTE_W-1:0] b, logic l);
			framed_word_t w;
			w.status = s;
			w.body_byte = b;
			w.last = l;
			owed_words.push_back(w);
		endfunction

		function int unsigned pending();
			return owed_words.size();
		endfunction

		// Advance the framing state by one accepted stream word
		function void take_stream_word(logic m, logic [rmd_pkg::BYTE_W-1:0] b);
			bit clean;
			if (halted)
				return;
			if (m == rmd_pkg::MODE_EOS) begin
				clean = !in_body && hdr_count == 0;
				restart_framing();
				owe(clean ? rmd_pkg::ST_CLOSE : rmd_pkg::ST_RESET, '0, 1'b0);
				return;
			end
			if (in_body) begin
				bytes_left = bytes_left - 1'b1;
				if (bytes_left == 0) begin
					restart_framing();
					owe(rmd_pkg::ST_BODY, b, 1'b1);
				end else begin
					owe(rmd_pkg::ST_BODY, b, 1'b0);
				end
				return;
			end
			hdr_value = {hdr_value[rmd_pkg::HDR_W-rmd_pkg::BYTE_W-1:0], b};
			hdr_count = hdr_count + 1'b1;
			if (hdr_count < rmd_pkg::HDR_BYTES)
				return;
			if (!hdr_value[rmd_pkg::HDR_W-1]) begin
				halted = 1'b1;
				owe(rmd_pkg::ST_FRAGMENT, '0, 1'b0);
				return;
			end
			bytes_left = hdr_value[rmd_pkg::LEN_W-1:0];
			hdr_count = '0;
			hdr_value = '0;
			if (bytes_left == 0) begin
				owe(rmd_pkg::ST_EMPTY, '0, 1'b0);
			end else if (bytes_left > max_len) begin
				halted = 1'b1;
				bytes_left = '0;
				owe(rmd_pkg::ST_TOO_LONG, '0, 1'b0);
			end else begin
				in_body = 1'b1;
			end
		endfunction

		// Compare one accepted result word against the oldest owed word
		function void check_output_word(logic [2:0] s, logic [rmd_pkg::BYTE_W-1:0] b,
				logic l);
			framed_word_t w;
			if (owed_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result word status %0d byte %02h last %0d",
						$realtime, s, b, l);
				return;
			end
			w = owed_words[0];
			owed_words.delete(0);
			if (s !== w.status || b !== w.body_byte || l !== w.last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: expected status %0d byte %02h last %0d, got %0d %02h %0d",
						$realtime, w.status, w.body_byte, w.last, s, b, l);
			end
		endfunction
	endclass

	logic                         clk;
	logic                         arst_n = 1'b0;
	logic                         item_valid = 1'b0;
	logic                         item_stall;
	logic                         mode = rmd_pkg::MODE_BYTE;
	logic [rmd_pkg::BYTE_W-1:0]   stream_byte = '0;
	logic                         result_valid;
	logic                         result_stall = 1'b0;
	logic [2:0]                   status;
	logic [rmd_pkg::BYTE_W-1:0]   body_byte;
	logic                         last;
	logic                         cfg_valid = 1'b0;
	logic                         cfg_ready;
	logic [rmd_pkg::LEN_W-1:0]    max_message_length = rmd_pkg::MAX_LEN_RESET;

	deframe_scoreboard   board = new();
	int unsigned         send_idle_pct = 0;
	int unsigned         recv_idle_pct = 0;
	int unsigned         words_sent = 0;

	record_marking_deframer_unit uut (
		.clk                (clk),
		.arst_n             (arst_n),
		.item_valid         (item_valid),
		.item_stall         (item_stall),
		.mode               (mode),
		.stream_byte        (stream_byte),
		.result_valid       (result_valid),
		.result_stall       (result_stall),
		.status             (status),
		.body_byte          (body_byte),
		.last               (last),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.max_message_length (max_message_length)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Offer one stream word, idling beforehand at the current rate, and hold it
	// until the block takes it. Valid is left high; the caller drops it.
	task automatic send_word(input logic m, input logic [rmd_pkg::BYTE_W-1:0] b);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		mode <= m;
		stream_byte <= b;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		board.take_stream_word(m, b);
		words_sent++;
	endtask

	task automatic send_header(input logic [rmd_pkg::HDR_W-1:0] h);
		for (int i = 0; i < rmd_pkg::HDR_BYTES; i++)
			send_word(rmd_pkg::MODE_BYTE,
				h[rmd_pkg::HDR_W-1-rmd_pkg::BYTE_W*i -: rmd_pkg::BYTE_W]);
	endtask

	task automatic send_bytes(input int unsigned n);
		repeat (n)
			send_word(rmd_pkg::MODE_BYTE, rmd_pkg::BYTE_W'($urandom_range(0, 255)));
	endtask

	// End of stream carries a random byte, which the block must disregard
	task automatic send_eos();
		send_word(rmd_pkg::MODE_EOS, rmd_pkg::BYTE_W'($urandom_range(0, 255)));
	endtask

	// Drop valid and hold off until every owed result word has come back
	task automatic wait_drained();
		item_valid <= 1'b0;
		do
			@(posedge clk);
		while (board.pending() != 0);
	endtask

	task automatic write_limit(input int unsigned lim);
		wait_drained();
		repeat (SETTLE_CYCLES)
			@(posedge clk);
		cfg_valid <= 1'b1;
		max_message_length <= rmd_pkg::LEN_W'(lim);
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		board.max_len = rmd_pkg::LEN_W'(lim);
	endtask

	// Mostly short bodies, some empty, a few long ones and the limit itself
	function automatic int unsigned pick_len(input int unsigned lim);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (lim == 0 || r < 10)
			return 0;
		if (r < 90)
			return $urandom_range(1, lim < 12 ? lim : 12);
		return lim <= 48 ? lim : $urandom_range(13, 48);
	endfunction

	// Mostly well-formed messages with random bodies; the rest are clean
	// closes, headers cut short, bodies cut short and huge lengths abandoned
	// after a few bytes. Every frame ends on a header boundary.
	task automatic run_random_phase(input int unsigned lim, input int unsigned n);
		int unsigned stop;
		int unsigned r;
		int unsigned len;
		stop = words_sent + n;
		// Open with a message of exactly the limit, abandoned after one byte when the limit is above one
		send_header({1'b1, rmd_pkg::LEN_W'(lim)});
		if (lim == 1) begin
			send_bytes(1);
		end else if (lim > 1) begin
			send_bytes(1);
			send_eos();
		end
		while (words_sent < stop) begin
			if ($urandom_range(0, 99) < 2)
				wait_drained();
			r = $urandom_range(0, 99);
			if (r < 70) begin
				len = pick_len(lim);
				send_header({1'b1, rmd_pkg::LEN_W'(len)});
				send_bytes(len);
			end else if (r < 78) begin
				send_eos();
			end else if (r < 86 || lim == 0) begin
				send_bytes($urandom_range(1, rmd_pkg::HDR_BYTES - 1));
				send_eos();
			end else if (r < 94) begin
				len = $urandom_range(1, lim < 48 ? lim : 48);
				send_header({1'b1, rmd_pkg::LEN_W'(len)});
				send_bytes($urandom_range(0, len - 1));
				send_eos();
			end else begin
				len = $urandom_range(1, lim);
				send_header({1'b1, rmd_pkg::LEN_W'(len)});
				send_bytes($urandom_range(0, len > 3 ? 3 : len - 1));
				send_eos();
			end
		end
	endtask

	// Result side: check each accepted word, then choose the next stall
	initial begin
		forever begin
			@(posedge clk);
			if (result_valid && !result_stall)
				board.check_output_word(status, body_byte, last);
			result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	// Watchdog: end the run if no word moves on any channel for too long
	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
					(cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Verification failed");
		$finish;
	end

	initial begin
		int unsigned limits [PHASES];
		repeat (9)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 31;
		recv_idle_pct = 79;

		// Directed words at the reset limit: empty message, single zero byte,
		// two all-ones bytes, clean close, header cut short, then a body of
		// exactly the limit abandoned after one byte
		send_header(32'h8000_0000);
		send_header(32'h8000_0001);
		send_word(rmd_pkg::MODE_BYTE, 8'h00);
		send_header(32'h8000_0002);
		send_word(rmd_pkg::MODE_BYTE, 8'hff);
		send_word(rmd_pkg::MODE_BYTE, 8'hff);
		send_eos();
		send_word(rmd_pkg::MODE_BYTE, 8'h80);
		send_word(rmd_pkg::MODE_BYTE, 8'h00);
		send_eos();
		send_header({1'b1, rmd_pkg::MAX_LEN_RESET});
		send_word(rmd_pkg::MODE_BYTE, 8'h5a);
		send_eos();

		// Limits per phase: zero, the largest, one, a small random value, the largest
		// again and a small random value; the last stays small so that a too-long header can follow it
		limits[0] = 0;
		limits[1] = 32'h7fff_ffff;
		limits[2] = 1;
		limits[3] = $urandom_range(2, 64);
		limits[4] = 32'h7fff_ffff;
		limits[5] = $urandom_range(1, 200);

		for (int p = 0; p < PHASES; p++) begin
			if (p == 2) begin
				send_idle_pct = 79;
				recv_idle_pct = 31;
			end else if (p == 4) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			write_limit(limits[p]);
			run_random_phase(limits[p], PHASE_WORDS);
		end

		// Close with an error, which halts the block for good; pick which one
		// at random, then feed a few words that must all be ignored
		wait_drained();
		if ($urandom_range(0, 1) == 0) begin
			send_header({1'b0, rmd_pkg::LEN_W'($urandom_range(0, 32'h7fff_ffff))});
		end else begin
			send_header({1'b1, rmd_pkg::LEN_W'($urandom_range(limits[PHASES-1] + 1,
				32'h7fff_ffff))});
		end
		repeat (8)
			send_word(1'($urandom_range(0, 1)), rmd_pkg::BYTE_W'($urandom_range(0, 255)));

		wait_drained();
		repeat (SETTLE_CYCLES)
			@(posedge clk);

		if (board.mismatches == 0 && board.pending() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

[files.f]
hdl/rmd_pkg.sv
hdl/rmd_frame_core.sv
hdl/record_marking_deframer_unit.sv
tb/record_marking_deframer_unit_test.sv
